@@ hdl/bcnc_pkg.sv @@
// shared types, constants and helpers for the branch coverage novelty check
// no dependencies
package bcnc_pkg;

  // default sizes
  localparam int unsigned MAP_SIZE_DEF    = 65536;
  localparam int unsigned VISITED_MAX_DEF = 256;

  // stored hash width
  localparam int unsigned HASH_W = 16;

  // xxh32 primes
  localparam logic [31:0] XP1 = 32'd2654435761;
  localparam logic [31:0] XP2 = 32'd2246822519;
  localparam logic [31:0] XP3 = 32'd3266489917;
  localparam logic [31:0] XP4 = 32'd668265263;
  localparam logic [31:0] XP5 = 32'd374761393;

  // cause codes
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_COV  = 2'd1;
  localparam logic [1:0] CAUSE_CTX  = 2'd2;

  typedef struct packed {
    logic [63:0] branch_pc;
    logic        branch_taken;
  } in_word_t;

  typedef struct packed {
    logic       interesting;
    logic [1:0] cause;
  } out_word_t;

  // hashes of both directions of one branch
  typedef struct packed {
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] ih;
  } edge_pair_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH_T,
    F_HASH_I,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_EDGE_RD,
    B_EDGE_CAP,
    B_CTX_RD,
    B_CTX_START,
    B_CTX_WAIT,
    B_CTX_BRD,
    B_CTX_BWR,
    B_INSERT,
    B_COV,
    B_INV_RD,
    B_INV_WR,
    B_RESULT
  } back_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    rotl32 = (x << r) | (x >> (6'd32 - {1'b0, r}));
  endfunction

endpackage

@@ hdl/bcnc_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module bcnc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bcnc_xxh.sv @@
// multi-cycle xxh32 (seed 0) over 9 bytes or 16 bytes, one multiply per cycle
// depends on bcnc_pkg
module bcnc_xxh (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         long_mode,
  input  logic [127:0] data,
  output logic         done,
  output logic [31:0]  result
);

  localparam logic [31:0] SEED_SHORT = 32'(bcnc_pkg::XP5 + 32'd9);
  localparam logic [31:0] LANE1      = 32'(bcnc_pkg::XP1 + bcnc_pkg::XP2);
  localparam logic [31:0] LANE4      = 32'(32'd0 - bcnc_pkg::XP1);

  logic         busy;
  logic         long_r;
  logic [3:0]   step;
  logic [127:0] w;
  logic [31:0]  acc;
  logic [31:0]  v;
  logic [31:0]  acc_next;
  logic [31:0]  v_next;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [31:0]  prod;
  logic         last;

  assign last = long_r ? (step == 4'd9) : (step == 4'd7);

  // operand select, one product, then the step's post operation
  always_comb begin
    mul_a    = acc;
    mul_b    = bcnc_pkg::XP1;
    acc_next = acc;
    v_next   = v;
    if (!long_r) begin
      case (step)
        4'd0: begin mul_a = w[31:0];  mul_b = bcnc_pkg::XP3; end
        4'd1: begin mul_a = bcnc_pkg::rotl32(acc, 5'd17); mul_b = bcnc_pkg::XP4; end
        4'd2: begin mul_a = w[63:32]; mul_b = bcnc_pkg::XP3; end
        4'd3: begin mul_a = bcnc_pkg::rotl32(acc, 5'd17); mul_b = bcnc_pkg::XP4; end
        4'd4: begin mul_a = {24'd0, w[71:64]}; mul_b = bcnc_pkg::XP5; end
        4'd5: begin mul_a = bcnc_pkg::rotl32(acc, 5'd11); mul_b = bcnc_pkg::XP1; end
        4'd6: begin mul_a = acc ^ (acc >> 15); mul_b = bcnc_pkg::XP2; end
        4'd7: begin mul_a = acc ^ (acc >> 13); mul_b = bcnc_pkg::XP3; end
        default: begin mul_a = acc; mul_b = bcnc_pkg::XP1; end
      endcase
    end else begin
      case (step)
        4'd0: begin mul_a = w[31:0];   mul_b = bcnc_pkg::XP2; end
        4'd2: begin mul_a = w[63:32];  mul_b = bcnc_pkg::XP2; end
        4'd4: begin mul_a = w[95:64];  mul_b = bcnc_pkg::XP2; end
        4'd6: begin mul_a = w[127:96]; mul_b = bcnc_pkg::XP2; end
        4'd1, 4'd3, 4'd5, 4'd7: begin mul_a = v; mul_b = bcnc_pkg::XP1; end
        4'd8: begin mul_a = acc ^ (acc >> 15); mul_b = bcnc_pkg::XP2; end
        4'd9: begin mul_a = acc ^ (acc >> 13); mul_b = bcnc_pkg::XP3; end
        default: begin mul_a = acc; mul_b = bcnc_pkg::XP1; end
      endcase
    end
    prod = 32'(mul_a * mul_b);
    if (!long_r) begin
      case (step)
        4'd0:       acc_next = 32'(SEED_SHORT + prod);
        4'd2, 4'd4: acc_next = 32'(acc + prod);
        default:    acc_next = prod;
      endcase
    end else begin
      case (step)
        4'd0: begin
          v_next   = bcnc_pkg::rotl32(32'(LANE1 + prod), 5'd13);
          acc_next = 32'd16;
        end
        4'd1: acc_next = 32'(acc + bcnc_pkg::rotl32(prod, 5'd1));
        4'd2: v_next   = bcnc_pkg::rotl32(32'(bcnc_pkg::XP2 + prod), 5'd13);
        4'd3: acc_next = 32'(acc + bcnc_pkg::rotl32(prod, 5'd7));
        4'd4: v_next   = bcnc_pkg::rotl32(prod, 5'd13);
        4'd5: acc_next = 32'(acc + bcnc_pkg::rotl32(prod, 5'd12));
        4'd6: v_next   = bcnc_pkg::rotl32(32'(LANE4 + prod), 5'd13);
        4'd7: acc_next = 32'(acc + bcnc_pkg::rotl32(prod, 5'd18));
        default: acc_next = prod;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        step   <= 4'd0;
        long_r <= long_mode;
        w      <= data;
      end else if (busy) begin
        acc  <= acc_next;
        v    <= v_next;
        step <= step + 4'd1;
        if (last) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= acc_next ^ (acc_next >> 16);
        end
      end
    end
  end

endmodule

@@ hdl/bcnc_fifo.sv @@
// two-entry queue of edge hash pairs between front and back
// depends on bcnc_pkg
module bcnc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bcnc_pkg::edge_pair_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output bcnc_pkg::edge_pair_t q_data
);

  bcnc_pkg::edge_pair_t entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_data  = entries[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

endmodule

@@ hdl/bcnc_front.sv @@
// front part: accepts branch words and hashes both directions
// depends on bcnc_pkg, bcnc_xxh
module bcnc_front #(
  parameter int unsigned MAP_SIZE = bcnc_pkg::MAP_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clearing,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bcnc_pkg::in_word_t   in_word,
  output logic                 push,
  output bcnc_pkg::edge_pair_t push_data,
  input  logic                 full
);

  localparam int unsigned MAP_BITS = $clog2(MAP_SIZE);

  bcnc_pkg::front_state_t state;
  bcnc_pkg::front_state_t state_next;
  logic [63:0]            pc_r;
  logic                   taken_r;
  logic [MAP_BITS-1:0]    h_r;
  logic [MAP_BITS-1:0]    ih_r;
  logic                   accept;
  logic                   eng_start;
  logic [127:0]           eng_data;
  logic                   eng_done;
  logic [31:0]            eng_res;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bcnc_pkg::F_IDLE:   if (accept)   state_next = bcnc_pkg::F_HASH_T;
      bcnc_pkg::F_HASH_T: if (eng_done) state_next = bcnc_pkg::F_HASH_I;
      bcnc_pkg::F_HASH_I: if (eng_done) state_next = bcnc_pkg::F_PUSH;
      bcnc_pkg::F_PUSH:   if (!full)    state_next = bcnc_pkg::F_IDLE;
      default:                          state_next = bcnc_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == bcnc_pkg::F_IDLE) && !clearing;
    push      = (state == bcnc_pkg::F_PUSH) && !full;
    eng_start = accept || ((state == bcnc_pkg::F_HASH_T) && eng_done);
    if (state == bcnc_pkg::F_IDLE) begin
      eng_data = {56'd0, 7'd0, in_word.branch_taken, in_word.branch_pc};
    end else begin
      eng_data = {56'd0, 7'd0, ~taken_r, pc_r};
    end
    push_data.h  = bcnc_pkg::HASH_W'(h_r);
    push_data.ih = bcnc_pkg::HASH_W'(ih_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcnc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // word capture and hash results
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r    <= in_word.branch_pc;
      taken_r <= in_word.branch_taken;
    end
    if (state == bcnc_pkg::F_HASH_T && eng_done) begin
      h_r <= eng_res[MAP_BITS-1:0];
    end
    if (state == bcnc_pkg::F_HASH_I && eng_done) begin
      ih_r <= eng_res[MAP_BITS-1:0];
    end
  end

  bcnc_xxh u_xxh (
    .clk       (clk),
    .rst       (rst),
    .start     (eng_start),
    .long_mode (1'b0),
    .data      (eng_data),
    .done      (eng_done),
    .result    (eng_res)
  );

endmodule

@@ hdl/bcnc_back.sv @@
// back part: map updates, context check, visited set and result register
// depends on bcnc_pkg, bcnc_ram, bcnc_xxh
module bcnc_back #(
  parameter int unsigned MAP_SIZE    = bcnc_pkg::MAP_SIZE_DEF,
  parameter int unsigned VISITED_MAX = bcnc_pkg::VISITED_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 clearing,
  input  logic                 q_valid,
  input  bcnc_pkg::edge_pair_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcnc_pkg::out_word_t  out_word
);

  localparam int unsigned MAP_BITS = $clog2(MAP_SIZE);
  localparam int unsigned X_BITS   = MAP_BITS + 3;
  localparam int unsigned VIS_AW   = (VISITED_MAX > 1) ? $clog2(VISITED_MAX) : 1;
  localparam int unsigned CNT_W    = $clog2(VISITED_MAX + 1);

  bcnc_pkg::back_state_t state;
  bcnc_pkg::back_state_t state_next;

  logic [MAP_BITS-1:0] h_r;
  logic [MAP_BITS-1:0] prev;
  logic [MAP_BITS-1:0] idx_r;
  logic [MAP_BITS-1:0] ii_r;
  logic [7:0]          old_r;
  logic [7:0]          covv_r;
  logic [CNT_W-1:0]    i_r;
  logic [CNT_W-1:0]    count_r;
  logic                fresh;
  logic                found;
  logic [X_BITS-1:0]   x_r;
  logic [MAP_BITS-1:0] clr_addr;
  logic [1:0]          cause_r;

  // ram ports
  logic                     hit_we, cov_we, ctx_we, vis_we;
  logic [MAP_BITS-1:0]      hit_waddr, cov_waddr, ctx_waddr;
  logic [7:0]               hit_wdata, cov_wdata, ctx_wdata;
  logic [MAP_BITS-1:0]      hit_raddr, cov_raddr, ctx_raddr;
  logic [7:0]               hit_rdata, cov_rdata, ctx_rdata;
  logic [VIS_AW-1:0]        vis_waddr, vis_raddr;
  logic [bcnc_pkg::HASH_W-1:0] vis_wdata, vis_rdata;

  logic         eng_start;
  logic [127:0] eng_data;
  logic         eng_done;
  logic [31:0]  eng_res;

  logic [7:0] new_cnt;
  logic       cov_new;
  logic       old_pow2;
  logic [7:0] bit_mask;
  logic       ins_ok;
  logic       out_load;

  assign new_cnt  = 8'(old_r + 8'd1);
  assign cov_new  = ((new_cnt | covv_r) != covv_r);
  assign old_pow2 = ((hit_rdata & 8'(hit_rdata - 8'd1)) == 8'd0);
  assign bit_mask = 8'(8'd1 << x_r[2:0]);
  assign ins_ok   = (old_r == 8'd0) && !found && (count_r < CNT_W'(VISITED_MAX));
  assign out_load = (state == bcnc_pkg::B_RESULT) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bcnc_pkg::B_CLEAR:     if (clr_addr == '1) state_next = bcnc_pkg::B_IDLE;
      bcnc_pkg::B_IDLE:      if (q_valid) state_next = bcnc_pkg::B_EDGE_RD;
      bcnc_pkg::B_EDGE_RD:   state_next = bcnc_pkg::B_EDGE_CAP;
      bcnc_pkg::B_EDGE_CAP: begin
        if (old_pow2 && count_r != '0) state_next = bcnc_pkg::B_CTX_RD;
        else                           state_next = bcnc_pkg::B_INSERT;
      end
      bcnc_pkg::B_CTX_RD:    state_next = bcnc_pkg::B_CTX_START;
      bcnc_pkg::B_CTX_START: state_next = bcnc_pkg::B_CTX_WAIT;
      bcnc_pkg::B_CTX_WAIT:  if (eng_done) state_next = bcnc_pkg::B_CTX_BRD;
      bcnc_pkg::B_CTX_BRD:   state_next = bcnc_pkg::B_CTX_BWR;
      bcnc_pkg::B_CTX_BWR: begin
        if (CNT_W'(i_r + 1'b1) == count_r) state_next = bcnc_pkg::B_INSERT;
        else                               state_next = bcnc_pkg::B_CTX_RD;
      end
      bcnc_pkg::B_INSERT:    state_next = bcnc_pkg::B_COV;
      bcnc_pkg::B_COV: begin
        if (cov_new) state_next = bcnc_pkg::B_INV_RD;
        else         state_next = bcnc_pkg::B_RESULT;
      end
      bcnc_pkg::B_INV_RD:    state_next = bcnc_pkg::B_INV_WR;
      bcnc_pkg::B_INV_WR:    state_next = bcnc_pkg::B_RESULT;
      bcnc_pkg::B_RESULT:    if (out_load) state_next = bcnc_pkg::B_IDLE;
      default:               state_next = bcnc_pkg::B_IDLE;
    endcase
  end

  // memory strobes and control outputs
  always_comb begin
    clearing  = (state == bcnc_pkg::B_CLEAR);
    q_pop     = (state == bcnc_pkg::B_IDLE) && q_valid;
    hit_we    = 1'b0;
    hit_waddr = idx_r;
    hit_wdata = new_cnt;
    cov_we    = 1'b0;
    cov_waddr = idx_r;
    cov_wdata = covv_r | new_cnt;
    ctx_we    = 1'b0;
    ctx_waddr = x_r[X_BITS-1:3];
    ctx_wdata = ctx_rdata | bit_mask;
    vis_we    = 1'b0;
    vis_waddr = count_r[VIS_AW-1:0];
    vis_wdata = bcnc_pkg::HASH_W'(h_r);
    hit_raddr = idx_r;
    cov_raddr = idx_r;
    ctx_raddr = x_r[X_BITS-1:3];
    vis_raddr = i_r[VIS_AW-1:0];
    eng_start = (state == bcnc_pkg::B_CTX_START);
    eng_data  = {32'd0, 16'd0, bcnc_pkg::HASH_W'(h_r), 32'd0, 16'd0, vis_rdata};
    case (state)
      bcnc_pkg::B_CLEAR: begin
        hit_we    = 1'b1;
        cov_we    = 1'b1;
        ctx_we    = 1'b1;
        hit_waddr = clr_addr;
        cov_waddr = clr_addr;
        ctx_waddr = clr_addr;
        hit_wdata = 8'd0;
        cov_wdata = 8'd0;
        ctx_wdata = 8'd0;
      end
      bcnc_pkg::B_CTX_BWR: ctx_we = ((ctx_rdata & bit_mask) == 8'd0);
      bcnc_pkg::B_INSERT:  vis_we = ins_ok;
      bcnc_pkg::B_COV: begin
        hit_we = 1'b1;
        cov_we = cov_new;
      end
      bcnc_pkg::B_INV_RD: begin
        hit_raddr = ii_r;
        cov_raddr = ii_r;
      end
      bcnc_pkg::B_INV_WR: begin
        cov_we    = 1'b1;
        cov_waddr = ii_r;
        cov_wdata = cov_rdata | 8'(hit_rdata + 8'd1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bcnc_pkg::B_CLEAR;
      clr_addr  <= '0;
      count_r   <= '0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bcnc_pkg::B_CLEAR) begin
        clr_addr <= MAP_BITS'(clr_addr + 1'b1);
      end
      if (state == bcnc_pkg::B_INSERT && ins_ok) begin
        count_r <= CNT_W'(count_r + 1'b1);
      end
      if (out_load) begin
        prev      <= h_r;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-word data registers
  always_ff @(posedge clk) begin
    case (state)
      bcnc_pkg::B_IDLE: begin
        h_r   <= q_data.h[MAP_BITS-1:0];
        idx_r <= (prev >> 1) ^ q_data.h[MAP_BITS-1:0];
        ii_r  <= (prev >> 1) ^ q_data.ih[MAP_BITS-1:0];
      end
      bcnc_pkg::B_EDGE_CAP: begin
        old_r  <= hit_rdata;
        covv_r <= cov_rdata;
        i_r    <= '0;
        fresh  <= 1'b0;
        found  <= 1'b0;
      end
      bcnc_pkg::B_CTX_START: begin
        if (vis_rdata == bcnc_pkg::HASH_W'(h_r)) found <= 1'b1;
      end
      bcnc_pkg::B_CTX_WAIT: begin
        if (eng_done) x_r <= eng_res[X_BITS-1:0];
      end
      bcnc_pkg::B_CTX_BWR: begin
        if ((ctx_rdata & bit_mask) == 8'd0) fresh <= 1'b1;
        i_r <= CNT_W'(i_r + 1'b1);
      end
      bcnc_pkg::B_COV: begin
        if (cov_new)    cause_r <= bcnc_pkg::CAUSE_COV;
        else if (fresh) cause_r <= bcnc_pkg::CAUSE_CTX;
        else            cause_r <= bcnc_pkg::CAUSE_NONE;
      end
      bcnc_pkg::B_RESULT: begin
        if (out_load) begin
          out_word.cause       <= cause_r;
          out_word.interesting <= (cause_r != bcnc_pkg::CAUSE_NONE);
        end
      end
      default: ;
    endcase
  end

  bcnc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_hit (
    .clk(clk), .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata),
    .raddr(hit_raddr), .rdata(hit_rdata)
  );

  bcnc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_cov (
    .clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
    .raddr(cov_raddr), .rdata(cov_rdata)
  );

  bcnc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_ctx (
    .clk(clk), .we(ctx_we), .waddr(ctx_waddr), .wdata(ctx_wdata),
    .raddr(ctx_raddr), .rdata(ctx_rdata)
  );

  bcnc_ram #(.WIDTH(bcnc_pkg::HASH_W), .DEPTH(VISITED_MAX)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  bcnc_xxh u_xxh (
    .clk       (clk),
    .rst       (rst),
    .start     (eng_start),
    .long_mode (1'b1),
    .data      (eng_data),
    .done      (eng_done),
    .result    (eng_res)
  );

`ifndef SYNTH
  // visited set never grows past its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count_r <= CNT_W'(VISITED_MAX))
    else $error("visited count above capacity");

  // an insert grows the visited set by exactly one
  a_insert: assert property (@(posedge clk) disable iff (rst)
    (state == bcnc_pkg::B_INSERT && ins_ok) |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("visited insert lost");

  // no result is offered while the maps are being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == bcnc_pkg::B_CLEAR) |-> (!out_valid && !q_pop))
    else $error("activity during clearing pass");

  // result word is consistent
  a_out_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.interesting == (out_word.cause != bcnc_pkg::CAUSE_NONE))
                  && (out_word.cause != 2'd3))
    else $error("bad result word");
`endif

endmodule

@@ hdl/branch_coverage_novelty_check.sv @@
// top level of the branch coverage novelty check
// depends on bcnc_pkg, bcnc_front, bcnc_fifo, bcnc_back
//
// Takes one branch word (pc, direction) and returns one result word saying
// whether it added edge coverage or a new context. After reset the block runs
// a clearing pass over the hit count, coverage and context maps, during which
// in_ready stays low. The front hashes both directions of a branch on one
// shared xxh32 unit and hands them to the back through a two-word queue. The
// back updates the maps for each word and, when the edge's old hit count is
// zero or a power of two, loops over each stored visited hash (read, 10-step
// xxh32, context map read-modify-write); that loop over the visited set sets
// the sustained rate. MAP_SIZE must be a power of two.
module branch_coverage_novelty_check #(
  parameter int unsigned MAP_SIZE    = bcnc_pkg::MAP_SIZE_DEF,
  parameter int unsigned VISITED_MAX = bcnc_pkg::VISITED_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcnc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output bcnc_pkg::out_word_t out_word
);

  logic                 clearing;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 q_valid;
  bcnc_pkg::edge_pair_t push_data;
  bcnc_pkg::edge_pair_t q_data;

  // hashing front
  bcnc_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // queue between the two parts
  bcnc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // map update back
  bcnc_back #(.MAP_SIZE(MAP_SIZE), .VISITED_MAX(VISITED_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ test/novelty_checker.sv @@
// checker for the branch coverage novelty check: watches both channels,
// tracks its own coverage, context and visited-hash state and compares results
// depends on bcnc_pkg
`timescale 1ns / 1ps

module novelty_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bcnc_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bcnc_pkg::out_word_t out_word,
  output int                  fails,
  output int                  pending
);

  localparam int MAP_N  = 65536;
  localparam int SEEN_N = 256;

  logic [7:0]  hit_cnt [0:MAP_N-1];
  logic [7:0]  cov_bits [0:MAP_N-1];
  logic [7:0]  ctx_map [0:MAP_N-1];
  logic [15:0] seen_hash [0:SEEN_N-1];
  int          seen_cnt;
  logic [15:0] prev_loc;
  bcnc_pkg::out_word_t expected_words [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_out(input logic [31:0] x);
    logic [31:0] h;
    h = x ^ (x >> 15);
    h = h * bcnc_pkg::XP2;
    h = h ^ (h >> 13);
    h = h * bcnc_pkg::XP3;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [31:0] lane(input logic [31:0] v, input logic [31:0] d);
    logic [31:0] p;
    p = d * bcnc_pkg::XP2;
    return rol(v + p, 13) * bcnc_pkg::XP1;
  endfunction

  // xxh32 over the 8 pc bytes and the direction byte
  function automatic logic [15:0] pc_hash(input logic [63:0] pc, input logic dir);
    logic [31:0] h;
    logic [31:0] p;
    h = bcnc_pkg::XP5 + 32'd9;
    p = pc[31:0] * bcnc_pkg::XP3;
    h = rol(h + p, 17) * bcnc_pkg::XP4;
    p = pc[63:32] * bcnc_pkg::XP3;
    h = rol(h + p, 17) * bcnc_pkg::XP4;
    p = {31'd0, dir} * bcnc_pkg::XP5;
    h = rol(h + p, 11) * bcnc_pkg::XP1;
    h = mix_out(h);
    return h[15:0];
  endfunction

  // xxh32 over two 8-byte words: stored hash, then current hash
  function automatic logic [18:0] ctx_hash(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] h;
    h = rol(lane(bcnc_pkg::XP1 + bcnc_pkg::XP2, {16'd0, a}), 1) +
        rol(lane(bcnc_pkg::XP2, 32'd0), 7) +
        rol(lane(32'd0, {16'd0, b}), 12) +
        rol(lane(32'd0 - bcnc_pkg::XP1, 32'd0), 18);
    h = mix_out(h + 32'd16);
    return h[18:0];
  endfunction

  task automatic predict_novelty(input bcnc_pkg::in_word_t w, output bcnc_pkg::out_word_t r);
    logic [15:0] h;
    logic [15:0] ih;
    logic [15:0] idx;
    logic [15:0] ii;
    logic [7:0]  old;
    logic [18:0] x;
    logic [7:0]  m;
    logic        fresh;
    logic        found;
    h = pc_hash(w.branch_pc, w.branch_taken);
    idx = (prev_loc >> 1) ^ h;
    old = hit_cnt[idx];
    fresh = 1'b0;
    // context pass on a zero or power-of-two old count
    if ((old & (old - 8'd1)) == 8'd0) begin
      for (int i = 0; i < seen_cnt; i++) begin
        x = ctx_hash(seen_hash[i], h);
        m = 8'd1 << x[2:0];
        if ((ctx_map[x[18:3]] & m) == 8'd0) begin
          ctx_map[x[18:3]] |= m;
          fresh = 1'b1;
        end
      end
      if (old == 8'd0) begin
        found = 1'b0;
        for (int i = 0; i < seen_cnt; i++)
          if (seen_hash[i] == h) found = 1'b1;
        if (!found && seen_cnt < SEEN_N) begin
          seen_hash[seen_cnt] = h;
          seen_cnt++;
        end
      end
    end
    hit_cnt[idx] = old + 8'd1;
    if ((hit_cnt[idx] | cov_bits[idx]) != cov_bits[idx]) begin
      ih = pc_hash(w.branch_pc, ~w.branch_taken);
      ii = (prev_loc >> 1) ^ ih;
      cov_bits[idx] |= hit_cnt[idx];
      cov_bits[ii] |= hit_cnt[ii] + 8'd1;
      r.cause = bcnc_pkg::CAUSE_COV;
    end else if (fresh) begin
      r.cause = bcnc_pkg::CAUSE_CTX;
    end else begin
      r.cause = bcnc_pkg::CAUSE_NONE;
    end
    r.interesting = (r.cause != bcnc_pkg::CAUSE_NONE);
    prev_loc = h;
  endtask

  // predict on each accepted branch word, compare each accepted result word
  always @(posedge clk) begin
    bcnc_pkg::out_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < MAP_N; i++) begin
        hit_cnt[i] = 8'd0;
        cov_bits[i] = 8'd0;
        ctx_map[i] = 8'd0;
      end
      seen_cnt = 0;
      prev_loc = 16'd0;
      expected_words.delete();
      fails <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_novelty(in_word, exp_w);
        expected_words.push_back(exp_w);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fails < 10) $display("unexpected result word %p", out_word);
          fails <= fails + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.interesting !== exp_w.interesting || out_word.cause !== exp_w.cause) begin
            if (fails < 10)
              $display("mismatch: expected interesting %0b cause %0d, got %0b %0d",
                       exp_w.interesting, exp_w.cause, out_word.interesting, out_word.cause);
            fails <= fails + 1;
          end
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

@@ test/tb_branch_coverage_novelty_check.sv @@
// stimulus and verdict for the branch coverage novelty check
// depends on bcnc_pkg, branch_coverage_novelty_check and novelty_checker
`timescale 1ns / 1ps

module tb_branch_coverage_novelty_check;

  localparam int STALL_LIMIT = 200000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  bcnc_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  bcnc_pkg::out_word_t out_word;
  int        fails;
  int        pending;
  logic      calm;
  logic      hold_req;
  int        quiet_cycles;
  logic [63:0] pool [0:23];

  branch_coverage_novelty_check dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  novelty_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one branch word and hold it until taken
  task automatic send_branch(input logic [63:0] pc, input logic dir);
    bcnc_pkg::in_word_t w;
    w.branch_pc = pc;
    w.branch_taken = dir;
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 3000; i++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_branch_coverage_novelty_check failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < 24; i++) pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme pcs, both directions, short repeats
    send_branch(64'd0, 1'b0);
    send_branch(64'd0, 1'b1);
    send_branch('1, 1'b0);
    send_branch('1, 1'b1);
    send_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 1'b0);
    send_branch(64'h8000_0000_0000_0000, 1'b1);
    send_branch(64'd1, 1'b0);
    for (int i = 0; i < 6; i++) send_branch(64'h0000_0000_0040_1000, 1'b1);
    for (int i = 0; i < 4; i++) send_branch(64'h0000_0000_0040_1000, 1'b0);
    send_branch(64'd0, 1'b0);
    send_branch('1, 1'b1);

    // loop-like traffic over a small set of branches, one long receiver hold-off
    for (int i = 0; i < 450; i++) begin
      if (i == 100) hold_req = 1'b1;
      send_branch(pool[$urandom_range(23)], 1'($urandom_range(1)));
    end

    // one branch hammered until its hit count wraps, with no idling
    drain_results();
    calm = 1'b1;
    for (int i = 0; i < 300; i++) send_branch(pool[0], 1'b1);
    calm = 1'b0;
    drain_results();

    // fresh branches until the visited set overflows
    for (int i = 0; i < 320; i++)
      send_branch({$urandom, $urandom}, 1'($urandom_range(1)));

    // mixed: mostly known branches, some noise
    for (int i = 0; i < 220; i++) begin
      if ($urandom_range(99) < 80)
        send_branch(pool[$urandom_range(23)], 1'($urandom_range(1)));
      else
        send_branch({$urandom, $urandom}, 1'($urandom_range(1)));
    end

    drain_results();
    repeat (4000) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("tb_branch_coverage_novelty_check passed");
    else
      $display("tb_branch_coverage_novelty_check failed");
    $finish;
  end

endmodule
